>>> rtl/infix_to_postfix_converter_defines.svh
// ----------------------------------------------------------------------------
// Infix to postfix converter assertion macros
// Assertion helpers shared by the converter RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define ITP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("infix_to_postfix_converter: implication check failed");
`define ITP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("infix_to_postfix_converter: invariant check failed");
`else
`define ITP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ITP_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif

`endif

>>> rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// Infix to postfix converter package
// Operator codes, character constants and the result record.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_MUL   = 8'h2A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DIV   = 8'h2F;

    typedef enum logic [2:0] {
        CODE_OPEN  = 3'd0,
        CODE_PLUS  = 3'd1,
        CODE_MINUS = 3'd2,
        CODE_MUL   = 3'd3,
        CODE_DIV   = 3'd4
    } code_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       overflow_error;
        logic       expression_done;
    } result_t;

    function automatic logic [7:0] code_char(input code_t code);
        logic [7:0] ch;
        case (code)
            CODE_OPEN:  ch = CHAR_OPEN;
            CODE_PLUS:  ch = CHAR_PLUS;
            CODE_MINUS: ch = CHAR_MINUS;
            CODE_MUL:   ch = CHAR_MUL;
            CODE_DIV:   ch = CHAR_DIV;
            default:    ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] code_weight(input code_t code);
        logic [1:0] w;
        case (code)
            CODE_PLUS, CODE_MINUS: w = 2'd1;
            CODE_MUL, CODE_DIV:    w = 2'd2;
            default:               w = 2'd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/itp_stack_ram.sv
// ----------------------------------------------------------------------------
// Operator stack memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module itp_stack_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  itp_pkg::code_t      wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output itp_pkg::code_t      rd_data
);
    import itp_pkg::*;

    code_t mem_reg [DEPTH];
    code_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// Infix to postfix converter
// Shunting-yard conversion of a character stream, operator stack in memory.
//
//   Channel  Direction  Payload
//   s_       in         tdata[7:0] character, tlast end_of_expression
//   m_       out        tdata[7:0] symbol, tuser has_symbol/overflow/done,
//                       tlast last_of_run
//
// A letter or an ignored character passes S_IDLE, S_POST and S_FIN. An operator on a
// non-empty stack also passes S_CHK, where it pops entries, and S_PUSH; a ')' on a
// non-empty stack passes S_CHK but not S_PUSH. With tlast set, S_FLUSH pops every
// stacked entry and S_DONE then emits the done item.
// aresetn empties the stack; the memory contents are not cleared.
// A stalled m_ side holds the converter once one result is pending.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] character
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [7:0] symbol
    output logic [2:0] m_tuser,  // [0] has_symbol, [1] overflow_error, [2] expression_done
    output logic       m_tlast
);
    import itp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_PUSH,
        S_POST,
        S_FLUSH,
        S_DONE,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    code_t            code_reg, code_next;
    logic             close_reg, close_next;
    logic             end_reg, end_next;
    result_t          pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;
    logic             m_valid_reg, m_valid_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    code_t            wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    code_t            rd_data;

    logic             produce;
    result_t          prod_res;
    logic             out_free;
    logic             can_produce;
    logic             in_letter;
    logic             in_op;
    code_t            in_code;
    logic             full;
    logic             pop_ok;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;

    itp_stack_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (IDX_W)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_letter = ((s_tdata >= 8'h41) && (s_tdata <= 8'h5A)) ||
                       ((s_tdata >= 8'h61) && (s_tdata <= 8'h7A));

    always_comb begin
        in_op   = 1'b1;
        in_code = CODE_OPEN;
        case (s_tdata)
            CHAR_PLUS:  in_code = CODE_PLUS;
            CHAR_MINUS: in_code = CODE_MINUS;
            CHAR_MUL:   in_code = CODE_MUL;
            CHAR_DIV:   in_code = CODE_DIV;
            default:    in_op   = 1'b0;
        endcase
    end

    assign full        = (count_reg == CNT_FULL);
    assign cnt_m1      = count_reg - CNT_W'(1);
    assign cnt_m2      = count_reg - CNT_W'(2);
    assign out_free    = !m_valid_reg || m_tready;
    assign can_produce = !pend_valid_reg || out_free;
    assign pop_ok      = (rd_data != CODE_OPEN) &&
                         (close_reg || (code_weight(rd_data) >= code_weight(code_reg)));
    assign s_tready    = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        code_next       = code_reg;
        close_next      = close_reg;
        end_next        = end_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = code_reg;
        rd_en           = 1'b0;
        rd_addr         = cnt_m1[IDX_W-1:0];
        produce         = 1'b0;
        prod_res        = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    end_next   = s_tlast;
                    code_next  = in_code;
                    close_next = (s_tdata == CHAR_CLOSE);
                    state_next = S_POST;
                    if (in_letter) begin
                        produce             = 1'b1;
                        prod_res.symbol     = s_tdata;
                        prod_res.has_symbol = 1'b1;
                    end else if (s_tdata == CHAR_OPEN) begin
                        if (full) begin
                            produce                 = 1'b1;
                            prod_res.overflow_error = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            wr_data    = CODE_OPEN;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end else if ((s_tdata == CHAR_CLOSE) || in_op) begin
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            state_next = S_CHK;
                        end else if (in_op) begin
                            wr_en      = 1'b1;
                            wr_data    = in_code;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            S_CHK: begin
                if (pop_ok) begin
                    if (can_produce) begin
                        produce             = 1'b1;
                        prod_res.symbol     = code_char(rd_data);
                        prod_res.has_symbol = 1'b1;
                        count_next          = cnt_m1;
                        if (count_reg > CNT_W'(1)) begin
                            rd_en   = 1'b1;
                            rd_addr = cnt_m2[IDX_W-1:0];
                        end else begin
                            state_next = close_reg ? S_POST : S_PUSH;
                        end
                    end
                end else if (close_reg) begin
                    count_next = cnt_m1;
                    state_next = S_POST;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                if (full) begin
                    if (can_produce) begin
                        produce                 = 1'b1;
                        prod_res.overflow_error = 1'b1;
                        state_next              = S_POST;
                    end
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_POST;
                end
            end
            S_POST: begin
                if (!end_reg) begin
                    state_next = S_FIN;
                end else if (count_reg != '0) begin
                    rd_en      = 1'b1;
                    state_next = S_FLUSH;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_FLUSH: begin
                if (can_produce) begin
                    produce             = 1'b1;
                    prod_res.symbol     = code_char(rd_data);
                    prod_res.has_symbol = 1'b1;
                    count_next          = cnt_m1;
                    if (count_reg > CNT_W'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_m2[IDX_W-1:0];
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (can_produce) begin
                    produce                  = 1'b1;
                    prod_res.expression_done = 1'b1;
                    state_next               = S_FIN;
                end
            end
            S_FIN: begin
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    m_data_next     = pend_reg;
                    m_last_next     = 1'b1;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A new result pushes the held one out, since it is no longer the last.
        if (produce) begin
            if (pend_valid_reg) begin
                m_data_next  = pend_reg;
                m_last_next  = 1'b0;
                m_valid_next = 1'b1;
            end
            pend_next       = prod_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        code_reg   <= code_next;
        close_reg  <= close_next;
        end_reg    <= end_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg.symbol;
    assign m_tuser  = {m_data_reg.expression_done, m_data_reg.overflow_error,
                       m_data_reg.has_symbol};
    assign m_tlast  = m_last_reg;

    `ITP_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_FULL)
    `ITP_ASSERT_IMPL(a_idle_no_pending, aclk, aresetn, state_reg == S_IDLE, !pend_valid_reg)
    `ITP_ASSERT_IMPL(a_pop_needs_entry, aclk, aresetn,
        (state_reg == S_CHK) || (state_reg == S_FLUSH), count_reg != '0)
    `ITP_ASSERT_IMPL(a_done_is_last, aclk, aresetn,
        m_valid_reg && m_data_reg.expression_done, m_last_reg)

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Infix to postfix converter testbench
// Sends character items and checks every postfix item the block emits against
// a model of the operator stack kept here. Directed tests cover letters,
// ignored bytes, all operators, parenthesis corner cases and a full stack.
// Random expressions with noise then run with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

    import itp_pkg::*;

    localparam int STACK_DEPTH    = 16;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LIMIT_CYCLES   = 1_000_000;
    localparam int RANDOM_ITEMS   = 400;

    localparam logic [7:0] GLYPH [5] = '{CHAR_OPEN, CHAR_PLUS, CHAR_MINUS, CHAR_MUL, CHAR_DIV};

    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       overflow_error;
        logic       last_of_run;
        logic       expression_done;
    } postfix_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    code_t       op_stack [STACK_DEPTH];
    int unsigned op_depth;
    postfix_t    run_q[$];
    postfix_t    postfix_q[$];
    int          err_count;
    int          cycle_count;
    int          random_items;
    bit          tx_steady;
    bit          rx_steady;

    infix_to_postfix_converter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Most gaps are short, a few are long, and steady stretches have none.
    function automatic int idle_len(input bit steady);
        int r;
        r = $urandom_range(99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    initial begin : drive_ready
        int stall;
        stall     = 0;
        rx_steady = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(199) == 0) begin
                rx_steady = ~rx_steady;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                stall = idle_len(rx_steady);
            end
        end
    end

    function automatic int unsigned rank_of(input code_t c);
        if (c == CODE_OPEN) begin
            return 0;
        end
        return (c >= CODE_MUL) ? 2 : 1;
    endfunction

    function automatic void emit(input logic [7:0] sym, input bit has, input bit ovf,
                                 input bit done);
        postfix_t r;
        r.symbol          = sym;
        r.has_symbol      = has;
        r.overflow_error  = ovf;
        r.last_of_run     = 1'b0;
        r.expression_done = done;
        run_q.push_back(r);
    endfunction

    function automatic void pop_operator();
        op_depth--;
        emit(GLYPH[op_stack[op_depth]], 1'b1, 1'b0, 1'b0);
    endfunction

    function automatic void push_operator(input code_t c);
        if (op_depth >= STACK_DEPTH) begin
            emit(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
            op_stack[op_depth] = c;
            op_depth++;
        end
    endfunction

    function automatic void convert_char(input logic [7:0] ch, input bit eoe);
        code_t    c;
        bit       is_op;
        postfix_t r;
        is_op = 1'b1;
        c = CODE_PLUS;
        run_q.delete();
        case (ch)
            CHAR_PLUS:  c = CODE_PLUS;
            CHAR_MINUS: c = CODE_MINUS;
            CHAR_MUL:   c = CODE_MUL;
            CHAR_DIV:   c = CODE_DIV;
            default:    is_op = 1'b0;
        endcase
        if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")) begin
            emit(ch, 1'b1, 1'b0, 1'b0);
        end else if (ch == CHAR_OPEN) begin
            push_operator(CODE_OPEN);
        end else if (ch == CHAR_CLOSE) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != CODE_OPEN) begin
                pop_operator();
            end
            if (op_depth > 0) begin
                op_depth--;
            end
        end else if (is_op) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != CODE_OPEN &&
                   rank_of(op_stack[op_depth - 1]) >= rank_of(c)) begin
                pop_operator();
            end
            push_operator(c);
        end
        if (eoe) begin
            while (op_depth > 0) begin
                pop_operator();
            end
            emit(8'h00, 1'b0, 1'b0, 1'b1);
        end
        foreach (run_q[i]) begin
            r = run_q[i];
            r.last_of_run = (i == run_q.size() - 1);
            postfix_q.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        postfix_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (postfix_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual data %0h user %0h last %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = postfix_q.pop_front();
                check_field("symbol", want.symbol, m_tdata);
                check_field("has_symbol", want.has_symbol, m_tuser[0]);
                check_field("overflow_error", want.overflow_error, m_tuser[1]);
                check_field("expression_done", want.expression_done, m_tuser[2]);
                check_field("last_of_run", want.last_of_run, m_tlast);
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input bit eoe);
        int gap;
        gap = idle_len(tx_steady);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = ch;
        s_tlast  = eoe;
        do @(posedge aclk); while (!s_tready);
        convert_char(ch, eoe);
    endtask

    task automatic send_string(input string text, input bit end_on_last);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], end_on_last && (i == text.len() - 1));
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (postfix_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1)) begin
            return 8'("A" + $urandom_range(25));
        end
        return 8'("a" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0:       return CHAR_PLUS;
            1:       return CHAR_MINUS;
            2:       return CHAR_MUL;
            default: return CHAR_DIV;
        endcase
    endfunction

    function automatic logic [7:0] random_noise();
        case ($urandom_range(3))
            0:       return CHAR_OPEN;
            1:       return CHAR_CLOSE;
            2:       return random_operator();
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_expression(input int operands, input int open_pct,
                                   input int noise_pct);
        logic [7:0] toks[$];
        int         depth;
        depth = 0;
        for (int i = 0; i < operands; i++) begin
            while (depth < 24 && $urandom_range(99) < open_pct) begin
                toks.push_back(CHAR_OPEN);
                depth++;
            end
            toks.push_back(random_letter());
            while (depth > 0 && $urandom_range(99) < 35) begin
                toks.push_back(CHAR_CLOSE);
                depth--;
            end
            if (i < operands - 1) begin
                toks.push_back(random_operator());
            end
        end
        while (depth > 0 && $urandom_range(99) < 85) begin
            toks.push_back(CHAR_CLOSE);
            depth--;
        end
        foreach (toks[i]) begin
            if ($urandom_range(99) < noise_pct) begin
                send_char(random_noise(), 1'b0);
                random_items++;
            end
            send_char(toks[i], i == toks.size() - 1);
            random_items++;
        end
    endtask

    task automatic test_letters_and_ignored();
        send_char("A", 1'b0);
        send_char("z", 1'b0);
        send_char("@", 1'b0);
        send_char("{", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("Z", 1'b0);
        send_char("a", 1'b0);
        send_char(" ", 1'b1);
        wait_drained();
    endtask

    task automatic test_operator_precedence();
        send_string("a+b*c-d/e", 1'b0);
        send_char(CHAR_MUL, 1'b1);
        wait_drained();
    endtask

    task automatic test_parentheses();
        send_string(")a+b)(c)((d", 1'b1);
        wait_drained();
    endtask

    task automatic test_stack_overflow();
        repeat (STACK_DEPTH) send_char(CHAR_OPEN, 1'b0);
        send_char(CHAR_PLUS, 1'b0);
        send_char(CHAR_OPEN, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_expressions();
        int style;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(3) == 0) begin
                tx_steady = ~tx_steady;
            end
            style = $urandom_range(99);
            if (style < 70) begin
                send_expression($urandom_range(1, 6), 20, 8);
            end else if (style < 82) begin
                send_expression($urandom_range(4, 9), 65, 5);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_char(random_noise(), $urandom_range(5) == 0);
                    random_items++;
                end
            end
            if (random_items > RANDOM_ITEMS / 2 && random_items < RANDOM_ITEMS / 2 + 12) begin
                wait_drained();
            end
        end
        send_char(")", 1'b1);
        wait_drained();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        op_depth    = 0;
        random_items = 0;
        tx_steady   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        test_letters_and_ignored();
        test_operator_precedence();
        test_parentheses();
        test_stack_overflow();
        test_random_expressions();

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
